>>> design/sitg_pkg.sv
`default_nettype none

package sitg_pkg;

    localparam int MAX_SECTORS_DEF = 32;

    // sector count and sector index widths; MAX_SECTORS may go up to 64
    localparam int CNT_W      = 7;
    localparam int S_W        = 9;
    localparam int SPT_W      = 6;
    localparam int ILV_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [SPT_W-1:0] SPT_RESET     = 6'd18;
    localparam logic [ILV_W-1:0] ILV_RESET     = 8'd1;
    localparam logic [7:0]       BAD_SIZE_CODE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_SPT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ILV = 1'b1;

    typedef struct packed {
        logic [7:0] cyl_number;
        logic [7:0] head_number;
        logic [5:0] first_sector;
        logic [7:0] size_code;
    } t_in;

    typedef struct packed {
        logic [7:0] id_cylinder;
        logic [7:0] id_head;
        logic [5:0] id_sector;
        logic [7:0] id_size;
        logic       last_id;
        logic       bad_size;
    } t_out;

    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic bad;
    } t_status;

endpackage

`default_nettype wire

>>> design/sitg_ctrl.sv
`default_nettype none

module sitg_ctrl
    import sitg_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  wire     i_out_stall,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_st.last || i_st.bad) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_RUN))
        else $error("accepted request did not start a run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && o_cmd.emit && (i_st.last || i_st.bad)) |=> (r_state == S_IDLE))
        else $error("final record did not return to idle");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.emit))
        else $error("output valid rose without an emit");

endmodule

`default_nettype wire

>>> design/sitg_dp.sv
`default_nettype none

module sitg_dp
    import sitg_pkg::*;
#(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_in                   i_in_data,
    input  t_cmd                  i_cmd,
    output t_status               o_st,
    output t_out                  o_out_data
);

    localparam int IDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

    logic [SPT_W-1:0]       r_spt;
    logic [ILV_W-1:0]       r_ilv;

    logic [7:0]             r_cyl, r_head, r_size;
    logic                   r_bad;
    logic [S_W-1:0]         r_s;
    logic [CNT_W-1:0]       r_count, r_n;
    logic [ILV_W-1:0]       r_step;
    logic [MAX_SECTORS-1:0] r_used;
    t_out                   r_out;

    logic [CNT_W-1:0]       ld_count;
    logic [S_W-1:0]         ld_s;
    logic [MAX_SECTORS-1:0] n_used;
    logic [S_W-1:0]         s_add, n_s;
    logic [IDX_W-1:0]       low_free;
    logic                   hit_used, last;
    t_out                   rec;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt <= SPT_RESET;
            r_ilv <= ILV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPT: r_spt <= i_cfg_data[SPT_W-1:0];
                REG_ILV: r_ilv <= i_cfg_data[ILV_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp count to 1..MAX_SECTORS
    always_comb begin
        if (r_spt == '0) begin
            ld_count = CNT_W'(1);
        end else if (CNT_W'(r_spt) > CNT_W'(MAX_SECTORS)) begin
            ld_count = CNT_W'(MAX_SECTORS);
        end else begin
            ld_count = CNT_W'(r_spt);
        end
        ld_s = (i_in_data.first_sector == '0) ? '0
                                               : S_W'(i_in_data.first_sector - 6'd1);
    end

    assign last = (CNT_W'(r_n + CNT_W'(1)) >= r_count);

    // map with the current sector marked; a first sector past the map is not marked
    always_comb begin
        n_used = r_used;
        if (r_s < S_W'(MAX_SECTORS)) begin
            n_used[r_s[IDX_W-1:0]] = 1'b1;
        end
    end

    // lowest unused sector below the count, zero when the track is full
    always_comb begin
        low_free = '0;
        for (int i = MAX_SECTORS - 1; i >= 0; i--) begin
            if (CNT_W'(i) < r_count && !n_used[i]) begin
                low_free = IDX_W'(i);
            end
        end
    end

    always_comb begin
        s_add    = r_s + S_W'(r_step);
        hit_used = (s_add < S_W'(r_count)) && n_used[s_add[IDX_W-1:0]];
        if (s_add >= S_W'(r_count) || hit_used) begin
            n_s = S_W'(low_free);
        end else begin
            n_s = s_add;
        end
    end

    always_comb begin
        rec = '0;
        if (r_bad) begin
            rec.bad_size = 1'b1;
        end else begin
            rec.id_cylinder = r_cyl;
            rec.id_head     = r_head;
            rec.id_sector   = 6'(r_s + S_W'(1));
            rec.id_size     = r_size;
            rec.last_id     = last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_n    <= '0;
        end else if (i_cmd.load) begin
            r_used <= '0;
            r_n    <= '0;
        end else if (i_cmd.emit && !r_bad) begin
            r_used <= n_used;
            r_n    <= CNT_W'(r_n + CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cyl   <= i_in_data.cyl_number;
            r_head  <= i_in_data.head_number;
            r_size  <= i_in_data.size_code;
            r_bad   <= (i_in_data.size_code == BAD_SIZE_CODE);
            r_s     <= ld_s;
            r_count <= ld_count;
            r_step  <= (r_ilv == '0) ? ILV_W'(1) : r_ilv;
        end else if (i_cmd.emit) begin
            r_s <= n_s;
        end
        if (i_cmd.emit) begin
            r_out <= rec;
        end
    end

    assign o_st.last  = last;
    assign o_st.bad   = r_bad;
    assign o_out_data = r_out;

endmodule

`default_nettype wire

>>> design/sector_interleave_table_gen.sv
`default_nettype none

// Sector ID table generator for formatting one floppy track.
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction is a
// track request with cylinder, head, first sector and size code.
// Output channel (o_out_valid / i_out_stall / o_out_data): one sector ID record
// per transaction, last_id set on the final record of the track. Size code
// 0xff yields a single record with only bad_size set.
// Config port: i_cfg_we writes register i_cfg_idx (0 = sectors per track,
// 1 = interleave) with i_cfg_data; write only while the block is idle.
// An accepted request is loaded, then the run state emits its records.
// Throughput: one record per cycle while the receiver does not stall,
// limited by the single shared index/used-map update; a request yields
// the sector count (clamped to 1..MAX_SECTORS) of records, one for a bad size;
// the next request is taken once the last record is in the output register.
// A stalled receiver holds the output register and freezes generation;
// nothing is dropped.
// Reset (synchronous, active low) returns to idle, empties the output
// register and restores sectors per track 18 and interleave 1.
module sector_interleave_table_gen
    import sitg_pkg::*;
#(
    parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output t_out                 o_out_data
);

    t_cmd    cmd;
    t_status st;

    sitg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    sitg_dp #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_st       (st),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
